>>> design/kvot_pkg.sv
// Package: parse modes, result codes, field widths and byte classes for the option tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package kvot_pkg;

  // Field widths
  localparam int unsigned CharW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ModeW   = 4;

  // Special bytes
  localparam logic [CharW-1:0] ChEquals    = 8'h3D;
  localparam logic [CharW-1:0] ChQuote     = 8'h27;
  localparam logic [CharW-1:0] ChBackslash = 8'h5C;
  localparam logic [CharW-1:0] ChSpace     = 8'h20;
  localparam logic [CharW-1:0] ChTab       = 8'h09;
  localparam logic [CharW-1:0] ChCr        = 8'h0D;

  // Parser modes
  typedef enum logic [ModeW-1:0] {
    MODE_SKIP_PRE    = 4'd0,
    MODE_NAME        = 4'd1,
    MODE_NAME_TRAIL  = 4'd2,
    MODE_SKIP_POST   = 4'd3,
    MODE_VAL_UNQ     = 4'd4,
    MODE_VAL_UNQ_ESC = 4'd5,
    MODE_VAL_Q       = 4'd6,
    MODE_VAL_Q_ESC   = 4'd7,
    MODE_ERROR       = 4'd8
  } mode_e;

  // Kind of byte carried in a result
  typedef enum logic [KindW-1:0] {
    KIND_NONE  = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_VALUE = 2'd2
  } kind_e;

  // Status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_NO_EQ  = 2'd1,
    ST_UNTERM = 2'd2
  } status_e;

  // One result item
  typedef struct packed {
    logic [CharW-1:0] char_out;
    kind_e            char_kind;
    logic             name_done;
    logic             pair_done;
    status_e          status;
    logic             text_done;
  } result_t;

  // Blank bytes: tab through carriage return, and space
  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage

`default_nettype wire

>>> design/kvot_if.sv
// Interfaces: option text input channel and token result channel.
`timescale 1ns / 1ps
`default_nettype none

interface kvot_text_if;
  logic                        valid;
  logic                        ready;
  logic [kvot_pkg::CharW-1:0]  text_char;
  logic                        is_end;

  modport source (output valid, output text_char, output is_end, input ready);
  modport sink   (input valid, input text_char, input is_end, output ready);
endinterface

interface kvot_result_if;
  logic                          valid;
  logic                          ready;
  logic [kvot_pkg::CharW-1:0]    char_out;
  logic [kvot_pkg::KindW-1:0]    char_kind;
  logic                          name_done;
  logic                          pair_done;
  logic [kvot_pkg::StatusW-1:0]  status;
  logic                          text_done;

  modport source (output valid, output char_out, output char_kind, output name_done,
                  output pair_done, output status, output text_done, input ready);
  modport sink   (input valid, input char_out, input char_kind, input name_done,
                  input pair_done, input status, input text_done, output ready);
endinterface

`default_nettype wire

>>> design/kvot_step.sv
// Next-mode and result logic for one byte or end item of the option text.
`timescale 1ns / 1ps
`default_nettype none

module kvot_step (
  input  kvot_pkg::mode_e                mode_i,
  input  logic [kvot_pkg::CharW-1:0]     text_char_i,
  input  logic                           is_end_i,
  output kvot_pkg::mode_e                mode_o,
  output kvot_pkg::result_t              result_o
);

  logic blank;
  assign blank = kvot_pkg::is_blank(text_char_i);

  always_comb begin
    mode_o             = mode_i;
    result_o           = '0;
    result_o.char_kind = kvot_pkg::KIND_NONE;
    result_o.status    = kvot_pkg::ST_OK;

    if (is_end_i) begin
      // End item: close whatever is open and rearm for the next text
      result_o.text_done = 1'b1;
      mode_o             = kvot_pkg::MODE_SKIP_PRE;
      case (mode_i)
        kvot_pkg::MODE_NAME,
        kvot_pkg::MODE_NAME_TRAIL:  result_o.status = kvot_pkg::ST_NO_EQ;
        kvot_pkg::MODE_SKIP_POST,
        kvot_pkg::MODE_VAL_UNQ,
        kvot_pkg::MODE_VAL_UNQ_ESC: result_o.pair_done = 1'b1;
        kvot_pkg::MODE_VAL_Q,
        kvot_pkg::MODE_VAL_Q_ESC:   result_o.status = kvot_pkg::ST_UNTERM;
        default: ;
      endcase
    end else begin
      unique case (mode_i)
        kvot_pkg::MODE_SKIP_PRE: begin
          if (blank) begin
            mode_o = mode_i;
          end else if (text_char_i == kvot_pkg::ChEquals) begin
            result_o.name_done = 1'b1;
            mode_o             = kvot_pkg::MODE_SKIP_POST;
          end else begin
            result_o.char_out  = text_char_i;
            result_o.char_kind = kvot_pkg::KIND_NAME;
            mode_o             = kvot_pkg::MODE_NAME;
          end
        end
        kvot_pkg::MODE_NAME: begin
          if (text_char_i == kvot_pkg::ChEquals) begin
            result_o.name_done = 1'b1;
            mode_o             = kvot_pkg::MODE_SKIP_POST;
          end else if (blank) begin
            mode_o = kvot_pkg::MODE_NAME_TRAIL;
          end else begin
            result_o.char_out  = text_char_i;
            result_o.char_kind = kvot_pkg::KIND_NAME;
          end
        end
        kvot_pkg::MODE_NAME_TRAIL: begin
          if (text_char_i == kvot_pkg::ChEquals) begin
            result_o.name_done = 1'b1;
            mode_o             = kvot_pkg::MODE_SKIP_POST;
          end else if (!blank) begin
            result_o.status = kvot_pkg::ST_NO_EQ;
            mode_o          = kvot_pkg::MODE_ERROR;
          end
        end
        kvot_pkg::MODE_SKIP_POST: begin
          if (blank) begin
            mode_o = mode_i;
          end else if (text_char_i == kvot_pkg::ChQuote) begin
            mode_o = kvot_pkg::MODE_VAL_Q;
          end else if (text_char_i == kvot_pkg::ChBackslash) begin
            mode_o = kvot_pkg::MODE_VAL_UNQ_ESC;
          end else begin
            result_o.char_out  = text_char_i;
            result_o.char_kind = kvot_pkg::KIND_VALUE;
            mode_o             = kvot_pkg::MODE_VAL_UNQ;
          end
        end
        kvot_pkg::MODE_VAL_UNQ: begin
          if (blank) begin
            result_o.pair_done = 1'b1;
            mode_o             = kvot_pkg::MODE_SKIP_PRE;
          end else if (text_char_i == kvot_pkg::ChBackslash) begin
            mode_o = kvot_pkg::MODE_VAL_UNQ_ESC;
          end else begin
            result_o.char_out  = text_char_i;
            result_o.char_kind = kvot_pkg::KIND_VALUE;
          end
        end
        kvot_pkg::MODE_VAL_UNQ_ESC: begin
          result_o.char_out  = text_char_i;
          result_o.char_kind = kvot_pkg::KIND_VALUE;
          mode_o             = kvot_pkg::MODE_VAL_UNQ;
        end
        kvot_pkg::MODE_VAL_Q: begin
          if (text_char_i == kvot_pkg::ChBackslash) begin
            mode_o = kvot_pkg::MODE_VAL_Q_ESC;
          end else if (text_char_i == kvot_pkg::ChQuote) begin
            result_o.pair_done = 1'b1;
            mode_o             = kvot_pkg::MODE_SKIP_PRE;
          end else begin
            result_o.char_out  = text_char_i;
            result_o.char_kind = kvot_pkg::KIND_VALUE;
          end
        end
        kvot_pkg::MODE_VAL_Q_ESC: begin
          result_o.char_out  = text_char_i;
          result_o.char_kind = kvot_pkg::KIND_VALUE;
          mode_o             = kvot_pkg::MODE_VAL_Q;
        end
        // Error mode and unused codes: drop bytes until the end item
        default: mode_o = kvot_pkg::MODE_ERROR;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/key_value_option_tokenizer.sv
// Top level: option text tokenizer with input register, step logic and result register.
//
//   channel   dir   modport  payload
//   text_i    in    sink     text_char[7:0], is_end
//   result_o  out   source   char_out[7:0], char_kind[1:0], name_done, pair_done,
//                            status[1:0], text_done
//
// One result per accepted item; each item passes the input register, then the result
// register, which drives result_o.valid and the result payload.
// One item per clock while result_o is ready; the parse mode register is the only loop.
// rst_ni clears the valid flags and returns the parser to skipping blanks before a name.
// A stalled result holds the result register; the input register still takes one
// more item, and the input stalls only when both registers are full.
`timescale 1ns / 1ps
`default_nettype none

module key_value_option_tokenizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  kvot_text_if.sink     text_i,
  kvot_result_if.source result_o
);

  // Input register
  logic                        in_valid_q;
  logic [kvot_pkg::CharW-1:0]  in_char_q;
  logic                        in_end_q;

  // Parser state and result register
  kvot_pkg::mode_e             mode_q, mode_d;
  kvot_pkg::result_t           res_d, res_q;
  logic                        out_valid_q;

  logic advance;
  logic in_take;

  // Move the held item into the result register when that register is free
  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign text_i.ready = !in_valid_q || advance;
  assign in_take      = text_i.valid && text_i.ready;

  kvot_step u_step (
    .mode_i      (mode_q),
    .text_char_i (in_char_q),
    .is_end_i    (in_end_q),
    .mode_o      (mode_d),
    .result_o    (res_d)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= kvot_pkg::MODE_SKIP_PRE;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        mode_q      <= mode_d;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= text_i.text_char;
      in_end_q  <= text_i.is_end;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Result channel
  assign result_o.valid     = out_valid_q;
  assign result_o.char_out  = res_q.char_out;
  assign result_o.char_kind = res_q.char_kind;
  assign result_o.name_done = res_q.name_done;
  assign result_o.pair_done = res_q.pair_done;
  assign result_o.status    = res_q.status;
  assign result_o.text_done = res_q.text_done;

endmodule

`default_nettype wire
